// ===== hdl/nnd_pkg.sv =====
// Shared types, constants and command/status structs for the nearest-neighbor downscaler.
package nnd_pkg;

   localparam int REG_W           = 13;
   localparam int REG_MAX         = 2 ** REG_W - 1;
   localparam int PIX_W           = 32;
   localparam int CSR_IDX_W       = 2;
   localparam int DEFAULT_MAX_DIM = 4096;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_EDGE      = 2'd2;

   localparam logic [REG_W-1:0] RST_SOURCE_WIDTH  = 13'd1;
   localparam logic [REG_W-1:0] RST_SOURCE_HEIGHT = 13'd1;
   localparam logic [REG_W-1:0] RST_MAX_EDGE      = 13'd4096;

   // divider jobs run during setup
   typedef enum logic [2:0] {
      OP_TW,      // target width from scale
      OP_TH,      // target height from scale
      OP_COL_Q,   // width / target width
      OP_COL_A,   // column pick accumulator
      OP_ROW_Q,   // height / target height
      OP_ROW_A    // row pick accumulator
   } op_type;

   typedef struct packed {
      op_type op;
      logic   div_start;
      logic   div_store;
      logic   frame_init;
      logic   set_keep;
      logic   pix_accept;
   } cmd_type;

   typedef struct packed {
      logic at_frame_start;
      logic need_scale;
      logic div_done;
      logic emit;
   } status_type;

endpackage

// ===== hdl/nnd_div.sv =====
// Restoring divider, one quotient bit per cycle, registered result.
module nnd_div #(
   parameter int NW = 2 * nnd_pkg::REG_W + 1,
   parameter int VW = nnd_pkg::REG_W + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient,
   output logic [VW-1:0] remainder
);

   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [VW:0]   shifted;
   logic          fits;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[NW-1]};
      fits    = shifted >= {1'b0, dvs_ff};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CW'(NW);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[NW-2:0], fits};
         rem_in = fits ? VW'(shifted - {1'b0, dvs_ff}) : shifted[VW-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== hdl/nnd_datapath.sv =====
// Datapath: size registers, frame position, pick accumulators, shared divider, result register.
module nnd_datapath #(
   parameter int MAX_DIM = nnd_pkg::DEFAULT_MAX_DIM
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic [nnd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nnd_pkg::REG_W-1:0]      csr_data,
   input  logic [nnd_pkg::PIX_W-1:0]      req_pixel_rgba,
   input  nnd_pkg::cmd_type               cmd,
   output nnd_pkg::status_type            status,
   output logic [nnd_pkg::PIX_W-1:0]      rsp_out_rgba,
   output logic                           rsp_out_last
);

   import nnd_pkg::*;

   localparam int DimLimit = (MAX_DIM < REG_MAX) ? MAX_DIM : REG_MAX;
   localparam int DW       = $clog2(DimLimit + 1);
   localparam int VW       = DW + 1;
   localparam int NW       = 2 * DW + 1;

   function automatic logic [DW-1:0] clamp_dim(input logic [REG_W-1:0] v);
      logic [DW-1:0] r;
      if (v == '0) r = DW'(1);
      else if (int'(v) > DimLimit) r = DW'(DimLimit);
      else r = DW'(v);
      return r;
   endfunction

   // min(q, dim - 1)
   function automatic logic [DW-1:0] fit_keep(input logic [VW-1:0] q,
                                               input logic [DW-1:0] dim);
      logic [DW-1:0] lim;
      lim = dim - DW'(1);
      return (q < VW'(lim)) ? q[DW-1:0] : lim;
   endfunction

   // configuration
   logic [REG_W-1:0] src_w_ff, src_w_in;
   logic [REG_W-1:0] src_h_ff, src_h_in;
   logic [REG_W-1:0] edge_ff, edge_in;

   // frame position
   logic [DW-1:0] col_cnt_ff, col_cnt_in;
   logic [DW-1:0] row_cnt_ff, row_cnt_in;
   logic [DW-1:0] tcol_ff, tcol_in;
   logic [DW-1:0] trow_ff, trow_in;
   logic [DW-1:0] keep_col_ff, keep_col_in;
   logic [DW-1:0] keep_row_ff, keep_row_in;
   logic [DW-1:0] tw_ff, tw_in;
   logic [DW-1:0] th_ff, th_in;

   // pick accumulators: step quotient/remainder and running quotient/remainder
   logic [DW-1:0] col_q_ff, col_q_in, col_r_ff, col_r_in;
   logic [VW-1:0] col_aq_ff, col_aq_in, col_ar_ff, col_ar_in;
   logic [DW-1:0] row_q_ff, row_q_in, row_r_ff, row_r_in;
   logic [VW-1:0] row_aq_ff, row_aq_in, row_ar_ff, row_ar_in;

   logic [PIX_W-1:0] rgba_ff, rgba_in;
   logic             last_ff, last_in;

   logic [DW-1:0]    w, h, longest, edge_dw;
   logic [REG_W-1:0] edge_nz;
   logic             need_scale;

   logic [VW-1:0] mul_a;
   logic [DW-1:0] mul_b, add_c;
   logic [NW-1:0] dividend;
   logic [VW-1:0] divisor;
   logic          div_done;
   logic [NW-1:0] quotient;
   logic [VW-1:0] remainder;

   logic          row_kept, emit, is_last, row_end, frame_end;
   logic [VW:0]   col_sum_r, row_sum_r;
   logic          col_wrap, row_wrap;
   logic [VW-1:0] col_adv_q, col_adv_r, row_adv_q, row_adv_r;
   logic [VW-1:0] col0_q, col0_r;

   assign w          = clamp_dim(src_w_ff);
   assign h          = clamp_dim(src_h_ff);
   assign longest    = (w > h) ? w : h;
   assign edge_nz    = (edge_ff == '0) ? REG_W'(1) : edge_ff;
   assign need_scale = REG_W'(longest) > edge_nz;
   // only used when scaling, so edge is below longest and fits
   assign edge_dw    = DW'(edge_nz);

   // one multiplier feeds the divider's dividend
   always_comb begin
      mul_a   = VW'(1);
      mul_b   = w;
      add_c   = '0;
      divisor = VW'(tw_ff);
      unique case (cmd.op)
         OP_TW: begin
            mul_a   = VW'(edge_dw);
            mul_b   = w;
            add_c   = longest >> 1;
            divisor = VW'(longest);
         end
         OP_TH: begin
            mul_a   = VW'(edge_dw);
            mul_b   = h;
            add_c   = longest >> 1;
            divisor = VW'(longest);
         end
         OP_COL_Q: begin
            mul_b   = w;
            divisor = VW'(tw_ff);
         end
         OP_COL_A: begin
            mul_a   = {tcol_ff, 1'b1};
            mul_b   = w;
            divisor = {tw_ff, 1'b0};
         end
         OP_ROW_Q: begin
            mul_b   = h;
            divisor = VW'(th_ff);
         end
         OP_ROW_A: begin
            mul_a   = {trow_ff, 1'b1};
            mul_b   = h;
            divisor = {th_ff, 1'b0};
         end
         default: begin
            mul_a   = VW'(1);
         end
      endcase
      dividend = NW'(mul_a) * NW'(mul_b) + NW'(add_c);
   end

   nnd_div #(
      .NW (NW),
      .VW (VW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dividend),
      .divisor   (divisor),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // per-pixel decisions
   assign row_kept  = (trow_ff < th_ff) && (row_cnt_ff == keep_row_ff);
   assign emit      = row_kept && (tcol_ff < tw_ff) && (col_cnt_ff == keep_col_ff);
   assign is_last   = (VW'(trow_ff) + VW'(1) >= VW'(th_ff)) &&
                      (VW'(tcol_ff) + VW'(1) >= VW'(tw_ff));
   assign row_end   = VW'(col_cnt_ff) + VW'(1) >= VW'(w);
   assign frame_end = VW'(row_cnt_ff) + VW'(1) >= VW'(h);

   // advance to the next target index: add 2*src = 2*Q*tgt + 2*R
   assign col_sum_r = (VW + 1)'(col_ar_ff) + (VW + 1)'({col_r_ff, 1'b0});
   assign col_wrap  = col_sum_r >= (VW + 1)'({tw_ff, 1'b0});
   assign col_adv_r = col_wrap ? VW'(col_sum_r - (VW + 1)'({tw_ff, 1'b0}))
                               : VW'(col_sum_r);
   assign col_adv_q = col_aq_ff + VW'(col_q_ff) + VW'(col_wrap);

   assign row_sum_r = (VW + 1)'(row_ar_ff) + (VW + 1)'({row_r_ff, 1'b0});
   assign row_wrap  = row_sum_r >= (VW + 1)'({th_ff, 1'b0});
   assign row_adv_r = row_wrap ? VW'(row_sum_r - (VW + 1)'({th_ff, 1'b0}))
                               : VW'(row_sum_r);
   assign row_adv_q = row_aq_ff + VW'(row_q_ff) + VW'(row_wrap);

   // target index zero: src / (2*tgt) from Q and R
   assign col0_q = VW'(col_q_ff >> 1);
   assign col0_r = col_q_ff[0] ? VW'(tw_ff) + VW'(col_r_ff) : VW'(col_r_ff);

   always_comb begin
      src_w_in    = src_w_ff;
      src_h_in    = src_h_ff;
      edge_in     = edge_ff;
      col_cnt_in  = col_cnt_ff;
      row_cnt_in  = row_cnt_ff;
      tcol_in     = tcol_ff;
      trow_in     = trow_ff;
      keep_col_in = keep_col_ff;
      keep_row_in = keep_row_ff;
      tw_in       = tw_ff;
      th_in       = th_ff;
      col_q_in    = col_q_ff;
      col_r_in    = col_r_ff;
      col_aq_in   = col_aq_ff;
      col_ar_in   = col_ar_ff;
      row_q_in    = row_q_ff;
      row_r_in    = row_r_ff;
      row_aq_in   = row_aq_ff;
      row_ar_in   = row_ar_ff;
      rgba_in     = rgba_ff;
      last_in     = last_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH:  src_w_in = csr_data;
            CSR_SOURCE_HEIGHT: src_h_in = csr_data;
            CSR_MAX_EDGE:      edge_in  = csr_data;
            default: ;
         endcase
      end

      if (cmd.frame_init) begin
         tcol_in = '0;
         trow_in = '0;
         if (!need_scale) begin
            tw_in = w;
            th_in = h;
         end
      end

      if (cmd.div_store) begin
         unique case (cmd.op)
            OP_TW: tw_in = (quotient == '0) ? DW'(1) : quotient[DW-1:0];
            OP_TH: th_in = (quotient == '0) ? DW'(1) : quotient[DW-1:0];
            OP_COL_Q: begin
               col_q_in = quotient[DW-1:0];
               col_r_in = remainder[DW-1:0];
            end
            OP_COL_A: begin
               col_aq_in = quotient[VW-1:0];
               col_ar_in = remainder;
               if (cmd.set_keep) keep_col_in = fit_keep(quotient[VW-1:0], w);
            end
            OP_ROW_Q: begin
               row_q_in = quotient[DW-1:0];
               row_r_in = remainder[DW-1:0];
            end
            OP_ROW_A: begin
               row_aq_in = quotient[VW-1:0];
               row_ar_in = remainder;
               if (cmd.set_keep) keep_row_in = fit_keep(quotient[VW-1:0], h);
            end
            default: ;
         endcase
      end

      if (cmd.pix_accept) begin
         if (emit) begin
            rgba_in   = req_pixel_rgba;
            last_in   = is_last;
            tcol_in   = tcol_ff + DW'(1);
            col_aq_in = col_adv_q;
            col_ar_in = col_adv_r;
            if (VW'(tcol_ff) + VW'(1) < VW'(tw_ff)) keep_col_in = fit_keep(col_adv_q, w);
         end
         if (row_end) begin
            col_cnt_in  = '0;
            tcol_in     = '0;
            col_aq_in   = col0_q;
            col_ar_in   = col0_r;
            keep_col_in = fit_keep(col0_q, w);
            if (row_kept) begin
               trow_in   = trow_ff + DW'(1);
               row_aq_in = row_adv_q;
               row_ar_in = row_adv_r;
               if (VW'(trow_ff) + VW'(1) < VW'(th_ff)) keep_row_in = fit_keep(row_adv_q, h);
            end
            if (frame_end) begin
               row_cnt_in  = '0;
               trow_in     = '0;
               keep_row_in = '0;
               keep_col_in = '0;
            end else begin
               row_cnt_in = row_cnt_ff + DW'(1);
            end
         end else begin
            col_cnt_in = col_cnt_ff + DW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff    <= RST_SOURCE_WIDTH;
         src_h_ff    <= RST_SOURCE_HEIGHT;
         edge_ff     <= RST_MAX_EDGE;
         col_cnt_ff  <= '0;
         row_cnt_ff  <= '0;
         tcol_ff     <= '0;
         trow_ff     <= '0;
         keep_col_ff <= '0;
         keep_row_ff <= '0;
         tw_ff       <= DW'(1);
         th_ff       <= DW'(1);
      end else begin
         src_w_ff    <= src_w_in;
         src_h_ff    <= src_h_in;
         edge_ff     <= edge_in;
         col_cnt_ff  <= col_cnt_in;
         row_cnt_ff  <= row_cnt_in;
         tcol_ff     <= tcol_in;
         trow_ff     <= trow_in;
         keep_col_ff <= keep_col_in;
         keep_row_ff <= keep_row_in;
         tw_ff       <= tw_in;
         th_ff       <= th_in;
      end
   end

   // accumulators are loaded by setup before the first pixel uses them
   always_ff @(posedge clock) begin
      col_q_ff  <= col_q_in;
      col_r_ff  <= col_r_in;
      col_aq_ff <= col_aq_in;
      col_ar_ff <= col_ar_in;
      row_q_ff  <= row_q_in;
      row_r_ff  <= row_r_in;
      row_aq_ff <= row_aq_in;
      row_ar_ff <= row_ar_in;
      rgba_ff   <= rgba_in;
      last_ff   <= last_in;
   end

   assign status.at_frame_start = (col_cnt_ff == '0) && (row_cnt_ff == '0);
   assign status.need_scale     = need_scale;
   assign status.div_done       = div_done;
   assign status.emit           = emit;

   assign rsp_out_rgba = rgba_ff;
   assign rsp_out_last = last_ff;

endmodule

// ===== hdl/nnd_ctrl.sv =====
// Controller: setup sequencing of divider jobs, pixel acceptance and result valid.
module nnd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                csr_valid,
   input  nnd_pkg::status_type status,
   output nnd_pkg::cmd_type    cmd
);

   import nnd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_INIT  = 4'b0010,
      ST_START = 4'b0100,
      ST_WAIT  = 4'b1000
   } state_type;

   function automatic op_type next_op(input op_type op);
      op_type r;
      unique case (op)
         OP_TW:    r = OP_TH;
         OP_TH:    r = OP_COL_Q;
         OP_COL_Q: r = OP_COL_A;
         OP_COL_A: r = OP_ROW_Q;
         OP_ROW_Q: r = OP_ROW_A;
         default:  r = OP_ROW_A;
      endcase
      return r;
   endfunction

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      full_ff, full_in;     // frame-start setup vs. resync after a csr write
   logic      done_ff, done_in;     // setup done for the pending frame start
   logic      dirty_ff, dirty_in;   // csr written since the last setup
   logic      rsp_valid_ff, rsp_valid_in;
   logic      setup_needed, accept;

   assign setup_needed = dirty_ff || (status.at_frame_start && !done_ff);
   assign req_ready    = (state_ff == ST_IDLE) && !setup_needed &&
                         (!rsp_valid_ff || rsp_ready);
   assign accept       = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      full_in      = full_ff;
      done_in      = done_ff;
      dirty_in     = dirty_ff;
      rsp_valid_in = rsp_valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && setup_needed) begin
               full_in = status.at_frame_start;
               if (status.at_frame_start) begin
                  state_in = ST_INIT;
               end else begin
                  op_in    = OP_COL_Q;
                  state_in = ST_START;
               end
            end
         end
         ST_INIT: begin
            op_in    = status.need_scale ? OP_TW : OP_COL_Q;
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.div_done) begin
               if (op_ff == OP_ROW_A) begin
                  state_in = ST_IDLE;
                  done_in  = 1'b1;
                  dirty_in = 1'b0;
               end else begin
                  op_in    = next_op(op_ff);
                  state_in = ST_START;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (accept) done_in = 1'b0;
      if (csr_valid) dirty_in = 1'b1;

      if (accept && status.emit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_COL_Q;
         full_ff      <= 1'b0;
         done_ff      <= 1'b0;
         dirty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         full_ff      <= full_in;
         done_ff      <= done_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign cmd.op         = op_ff;
   assign cmd.div_start  = (state_ff == ST_START);
   assign cmd.div_store  = (state_ff == ST_WAIT) && status.div_done;
   assign cmd.frame_init = (state_ff == ST_INIT);
   assign cmd.set_keep   = full_ff;
   assign cmd.pix_accept = accept;

endmodule

// ===== hdl/nearest_neighbor_downscaler.sv =====
// Top level of the nearest-neighbor downscaler: controller, datapath, csr port.
// Mid-frame pixels: one beat per cycle unless rsp stalls; result registered on acceptance.
// First pixel of a frame waits for setup on the shared 1-bit/cycle divider:
//   up to 6 jobs, each on a dividend of 2*DW + 1 bits, DW = bits of min(MAX_DIM, 8191).
// A mid-frame pixel after a csr write waits for a resync of 4 such jobs.
// Synchronous active-high reset restores the size registers and restarts the frame.
module nearest_neighbor_downscaler #(
   parameter int MAX_DIM = nnd_pkg::DEFAULT_MAX_DIM
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [nnd_pkg::PIX_W-1:0]     req_pixel_rgba,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [nnd_pkg::PIX_W-1:0]     rsp_out_rgba,
   output logic                          rsp_out_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [nnd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nnd_pkg::REG_W-1:0]     csr_data
);

   import nnd_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       csr_write;

   // writes are always accepted
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   nnd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_write),
      .status    (status),
      .cmd       (cmd)
   );

   nnd_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_pixel_rgba (req_pixel_rgba),
      .cmd            (cmd),
      .status         (status),
      .rsp_out_rgba   (rsp_out_rgba),
      .rsp_out_last   (rsp_out_last)
   );

endmodule

// ===== tb/nearest_neighbor_downscaler_test.sv =====
// Self-checking testbench for the nearest-neighbor downscaler: directed and random frames.
`timescale 1ns / 1ps

module nearest_neighbor_downscaler_test;
   import nnd_pkg::*;

   localparam int MAX_DIM        = DEFAULT_MAX_DIM;
   localparam int SETTLE_CYCLES  = 400;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int REPORT_LIMIT   = 10;

   // unmapped register index, writes to it must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic [PIX_W-1:0]     req_pixel_rgba = '0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic [PIX_W-1:0]     rsp_out_rgba;
   logic                 rsp_out_last;
   logic                 csr_valid      = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index      = '0;
   logic [REG_W-1:0]     csr_data       = '0;

   // mirrored register file
   logic [REG_W-1:0] src_w_reg    = RST_SOURCE_WIDTH;
   logic [REG_W-1:0] src_h_reg    = RST_SOURCE_HEIGHT;
   logic [REG_W-1:0] max_edge_reg = RST_MAX_EDGE;

   // mirrored frame walk
   logic [11:0] col_pos  = '0;
   logic [11:0] row_pos  = '0;
   logic [12:0] tgt_col  = '0;
   logic [12:0] tgt_row  = '0;
   logic [11:0] keep_col = '0;
   logic [11:0] keep_row = '0;
   logic [12:0] tgt_w    = 13'd1;
   logic [12:0] tgt_h    = 13'd1;

   logic [PIX_W-1:0] kept_rgba_q[$];
   logic             kept_last_q[$];
   int               kept_pending = 0;
   int               mismatches   = 0;

   bit gaps_on      = 1'b1;
   int hold_token   = 0;
   int hold_served  = 0;
   int hold_left    = 0;
   int quiet_cycles = 0;

   nearest_neighbor_downscaler uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_rgba (req_pixel_rgba),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_rgba   (rsp_out_rgba),
      .rsp_out_last   (rsp_out_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned clamp_size(input logic [REG_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   function automatic int unsigned scaled_size(input int unsigned dim, input int unsigned longest,
                                               input int unsigned lim);
      longint unsigned q;
      q = (longint'(dim) * longint'(lim) + longint'(longest / 2)) / longint'(longest);
      return (q < 1) ? 1 : int'(q);
   endfunction

   // source coordinate nearest to the center of target cell t
   function automatic int unsigned keep_position(input int unsigned t, input int unsigned src,
                                                 input int unsigned tgt);
      longint unsigned c;
      c = ((2 * longint'(t) + 1) * longint'(src)) / (2 * longint'(tgt));
      return (c < longint'(src) - 1) ? int'(c) : src - 1;
   endfunction

   // advance the frame walk by one source pixel; returns 1 if the pixel is kept
   function automatic bit downscale_step(input logic [PIX_W-1:0] pix,
                                         output logic [PIX_W-1:0] rgba, output logic last);
      int unsigned w, h, longest, lim;
      bit          row_hit, emit;
      w    = clamp_size(src_w_reg);
      h    = clamp_size(src_h_reg);
      rgba = pix;
      last = 1'b0;
      emit = 1'b0;
      // target size and keep positions latch on the first pixel of a frame
      if (col_pos == '0 && row_pos == '0) begin
         longest = (w > h) ? w : h;
         lim     = (max_edge_reg == '0) ? 1 : int'(max_edge_reg);
         if (longest > lim) begin
            tgt_w = 13'(scaled_size(w, longest, lim));
            tgt_h = 13'(scaled_size(h, longest, lim));
         end else begin
            tgt_w = 13'(w);
            tgt_h = 13'(h);
         end
         tgt_col  = '0;
         tgt_row  = '0;
         keep_col = 12'(keep_position(0, w, int'(tgt_w)));
         keep_row = 12'(keep_position(0, h, int'(tgt_h)));
      end
      row_hit = (tgt_row < tgt_h) && (row_pos == keep_row);
      if (row_hit && tgt_col < tgt_w && col_pos == keep_col) begin
         last    = (int'(tgt_row) + 1 >= int'(tgt_h)) && (int'(tgt_col) + 1 >= int'(tgt_w));
         emit    = 1'b1;
         tgt_col = tgt_col + 13'd1;
         if (tgt_col < tgt_w) keep_col = 12'(keep_position(int'(tgt_col), w, int'(tgt_w)));
      end
      // row and frame ends follow the live size registers
      if (int'(col_pos) + 1 >= w) begin
         col_pos  = '0;
         tgt_col  = '0;
         keep_col = 12'(keep_position(0, w, int'(tgt_w)));
         if (row_hit) begin
            tgt_row = tgt_row + 13'd1;
            if (tgt_row < tgt_h) keep_row = 12'(keep_position(int'(tgt_row), h, int'(tgt_h)));
         end
         if (int'(row_pos) + 1 >= h) begin
            row_pos  = '0;
            tgt_row  = '0;
            keep_row = '0;
            keep_col = '0;
         end else begin
            row_pos = row_pos + 12'd1;
         end
      end else begin
         col_pos = col_pos + 12'd1;
      end
      return emit;
   endfunction

   always @(posedge clock) begin : check_results
      logic [PIX_W-1:0] want_rgba;
      logic             want_last;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SOURCE_WIDTH:  src_w_reg = csr_data;
               CSR_SOURCE_HEIGHT: src_h_reg = csr_data;
               CSR_MAX_EDGE:      max_edge_reg = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (kept_pending == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected beat: rgba %h last %0b", rsp_out_rgba, rsp_out_last);
            end else begin
               want_rgba = kept_rgba_q.pop_front();
               want_last = kept_last_q.pop_front();
               kept_pending--;
               if (rsp_out_rgba !== want_rgba || rsp_out_last !== want_last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("mismatch: expected rgba %h last %0b, got rgba %h last %0b",
                              want_rgba, want_last, rsp_out_rgba, rsp_out_last);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (downscale_step(req_pixel_rgba, want_rgba, want_last)) begin
               kept_rgba_q = {kept_rgba_q, want_rgba};
               kept_last_q = {kept_last_q, want_last};
               kept_pending++;
            end
         end
      end
   end

   // receiver: random idling plus an on-demand long hold-off
   always @(posedge clock) begin
      if (hold_token != hold_served) begin
         hold_served <= hold_token;
         hold_left   <= HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(gaps_on && $urandom_range(99) < 20);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", quiet_cycles);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      if (gaps_on && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pixel_rgba <= pix;
      do @(posedge clock); while (!req_ready);
   endtask

   // leaves csr_valid high so back-to-back writes need no gap
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // wait for every kept pixel, then give in-flight setup time to finish
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      wait (kept_pending == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input int unsigned w, input int unsigned h, input int unsigned lim);
      drain_and_settle();
      csr_write(CSR_SOURCE_WIDTH, REG_W'(w));
      csr_write(CSR_SOURCE_HEIGHT, REG_W'(h));
      csr_write(CSR_MAX_EDGE, REG_W'(lim));
      csr_valid <= 1'b0;
   endtask

   task automatic run_random_frames(input int unsigned budget);
      int unsigned sent, w, h, lim, wc, hc, pixels;
      sent = 0;
      while (sent < budget) begin
         w = $urandom_range(12, 1);
         h = $urandom_range(12, 1);
         // now and then a long thin image
         if ($urandom_range(9) == 0) begin
            w = $urandom_range(100, 20);
            h = $urandom_range(2, 1);
            if ($urandom_range(1) == 1) begin
               h = w;
               w = $urandom_range(2, 1);
            end
         end
         if ($urandom_range(19) == 0) w = 0;
         if ($urandom_range(19) == 0) h = 0;
         case ($urandom_range(7))
            0:       lim = 0;
            1:       lim = REG_MAX;
            2:       lim = MAX_DIM;
            default: lim = $urandom_range(16, 1);
         endcase
         configure(w, h, lim);
         wc     = (w == 0) ? 1 : w;
         hc     = (h == 0) ? 1 : h;
         pixels = wc * hc * $urandom_range(2, 1);
         // a partial frame leaves the next write landing mid-frame
         if ($urandom_range(9) < 3) pixels += $urandom_range(wc * hc - 1, 0);
         if (pixels > budget - sent) pixels = budget - sent;
         repeat (pixels) send_pixel($urandom);
         sent += pixels;
      end
   endtask

   // 1x1 frames at reset values: every beat passes and is last
   task automatic test_reset_values();
      send_pixel(32'h0000_0000);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h5AA5_C33C);
   endtask

   task automatic test_zero_registers();
      configure(0, 0, 0);
      send_pixel(32'hA5A5_5A5A);
      send_pixel(32'h0123_4567);
   endtask

   // oversize width clamps; a resize mid-row cuts the frame short
   task automatic test_midframe_resize();
      configure(REG_MAX, 1, 1);
      repeat (3) send_pixel($urandom);
      configure(3, 2, 2);
      drain_and_settle();
      csr_write(CSR_SPARE, REG_W'(REG_MAX));
      csr_valid <= 1'b0;
      repeat (10) send_pixel($urandom);
   endtask

   // output held off while the sender keeps offering pass-through pixels
   task automatic test_output_backpressure();
      configure(8, 8, MAX_DIM);
      @(negedge clock);
      hold_token++;
      @(posedge clock);
      repeat (64) send_pixel($urandom);
   endtask

   task automatic test_tall_frame();
      configure(1, MAX_DIM, MAX_DIM);
      send_pixel(32'hFFFF_0000);
      send_pixel(32'h0000_FFFF);
   endtask

   task automatic test_random_frames();
      run_random_frames(480);
   endtask

   task automatic test_no_idle_stretch();
      gaps_on = 1'b0;
      run_random_frames(200);
      gaps_on = 1'b1;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_zero_registers();
      test_midframe_resize();
      test_output_backpressure();
      test_tall_frame();
      test_random_frames();
      test_no_idle_stretch();
      drain_and_settle();
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/nnd_pkg.sv
hdl/nnd_div.sv
hdl/nnd_datapath.sv
hdl/nnd_ctrl.sv
hdl/nearest_neighbor_downscaler.sv
tb/nearest_neighbor_downscaler_test.sv
